// File: hw/rtl/fragment_reassembly_checker_macros.svh
// ----------------------------------------------------------------------------
// Fragment reassembly checker assertion macros
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_CHECKER_MACROS_SVH
`define FRAGMENT_REASSEMBLY_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly checker package
// Operation and result codes, widths and helpers shared by the RTL files.
// ----------------------------------------------------------------------------
package frc_pkg;

  // Largest message the reassembly buffer may hold.
  localparam int MAX_MESSAGE_BYTES = 65536;

  // Capacity, byte count and write pointer width.
  localparam int CAP_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int OFF_W = 16;
  localparam int MSG_W = 17;

  localparam logic [15:0] HDR_BYTES      = 16'd6;
  localparam logic [31:0] DEFAULT_CAP    = 32'd65536;
  localparam logic [31:0] MAX_CAP        = 32'(MAX_MESSAGE_BYTES);
  localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef enum logic [3:0] {
    KIND_FRAG_OK      = 4'd0,
    KIND_TOO_SHORT    = 4'd1,
    KIND_LENGTH_BAD   = 4'd2,
    KIND_TOO_LARGE    = 4'd3,
    KIND_MISSING      = 4'd4,
    KIND_TIMEOUT      = 4'd5,
    KIND_BYTE_WRITE   = 4'd6,
    KIND_COMPLETE     = 4'd7,
    KIND_BYTE_IGNORED = 4'd8
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] seq_num;
    logic [15:0] frag_count;
    logic [15:0] payload_size;
    logic [15:0] frame_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [15:0]      fragment_index;
    logic [15:0]      fragment_total;
    logic [15:0]      fragment_bytes;
    logic [OFF_W-1:0] write_offset;
    logic [7:0]       write_data;
    logic [MSG_W-1:0] message_length;
    logic             last;
  } result_t;

  // Message length as reported: the low MSG_W bits of a byte count.
  function automatic logic [MSG_W-1:0] to_msg(input logic [CAP_W-1:0] v);
    logic [CAP_W+MSG_W-1:0] wide;
    wide = {{MSG_W{1'b0}}, v};
    return wide[MSG_W-1:0];
  endfunction

  // Write offset as reported: the low OFF_W bits of the write pointer.
  function automatic logic [OFF_W-1:0] to_off(input logic [CAP_W-1:0] v);
    logic [CAP_W+OFF_W-1:0] wide;
    wide = {{OFF_W{1'b0}}, v};
    return wide[OFF_W-1:0];
  endfunction

endpackage

// File: hw/rtl/frc_in_if.sv
// ----------------------------------------------------------------------------
// Fragment reassembly checker input channel
// Valid/ready channel carrying one header, payload byte or tick.
// ----------------------------------------------------------------------------
interface frc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] seq_num;
  logic [15:0] frag_count;
  logic [15:0] payload_size;
  logic [15:0] frame_len;
  logic [7:0]  data_byte;

  modport source (
    output valid, operation, seq_num, frag_count, payload_size, frame_len, data_byte,
    input  ready
  );

  modport sink (
    input  valid, operation, seq_num, frag_count, payload_size, frame_len, data_byte,
    output ready
  );
endinterface

// File: hw/rtl/frc_out_if.sv
// ----------------------------------------------------------------------------
// Fragment reassembly checker result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface frc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [15:0] fragment_index;
  logic [15:0] fragment_total;
  logic [15:0] fragment_bytes;
  logic [15:0] write_offset;
  logic [7:0]  write_data;
  logic [16:0] message_length;
  logic        last;

  modport source (
    output valid, kind, fragment_index, fragment_total, fragment_bytes,
           write_offset, write_data, message_length, last,
    input  ready
  );

  modport sink (
    input  valid, kind, fragment_index, fragment_total, fragment_bytes,
           write_offset, write_data, message_length, last,
    output ready
  );
endinterface

// File: hw/rtl/fragment_reassembly_checker.sv
// ----------------------------------------------------------------------------
// Fragment reassembly checker
// Follows one chunked transfer and turns its fragments into byte writes.
// ----------------------------------------------------------------------------
// The in_ch channel carries decoded fragment headers, payload bytes and
// one millisecond ticks; each transfer moves one of them. The out_ch channel
// carries results, one per transfer: fragment verdicts, byte writes at a
// message offset, ignored bytes, completion with the message length, and
// timeouts. An item causes zero, one or two results, and the last result of
// an item has last set. The cfg_we / cfg_wdata port writes timeout_ticks.
// An accepted item is registered in the input register, evaluated once the
// result buffer has room, and its results are registered in the result
// buffer, from which the first of them is shown.
// One item is taken per cycle as long as each item causes at most one result
// and the receiver takes each result; an item with two results holds the
// input back while the two-entry result buffer drains one result per cycle.
// When the receiver stalls, the shown result holds, and the input register
// takes one more item if it is empty, then in_ch.ready drops.
// A synchronous reset empties the input register and the result buffer,
// drops any transfer in progress and sets timeout_ticks to 5000.
// ----------------------------------------------------------------------------
module fragment_reassembly_checker (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic [15:0] cfg_wdata,
  frc_in_if.sink    in_ch,
  frc_out_if.source out_ch
);
  import frc_pkg::*;

  localparam int SUM_W = ((CAP_W > 16) ? CAP_W : 16) + 1;

  // Transfer state. Clearing the transfer is a write of all zeros.
  typedef struct packed {
    logic             active;
    logic [15:0]      next_seq;
    logic [CAP_W-1:0] capacity;
    logic [CAP_W-1:0] received;
    logic [CAP_W-1:0] write_pointer;
    logic [15:0]      pending;
    logic             pending_is_last;
    logic [15:0]      idle_ticks;
  } xfer_t;

  logic [15:0] timeout_ticks;

  in_item_t hold;
  logic     hold_valid;

  xfer_t st, st_next;

  result_t     res0, res1, slot0, slot1;
  logic [1:0]  nres;
  logic [1:0]  count;

  logic fire, pop, room;

  // Header arithmetic.
  logic [31:0]      product;
  logic [31:0]      cap_calc;
  logic [SUM_W-1:0] recv_sum;
  logic [SUM_W-1:0] recv_new_wide;
  logic [CAP_W-1:0] recv_new;
  logic [16:0]      need_len;
  logic             is_last_frag;
  logic [15:0]      idle_inc;

  // The result buffer drains one result per cycle while the receiver takes them.
  // An item is evaluated only when the buffer will be empty after this cycle's
  // pop, so both of its results always fit.
  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (count == 2'd0) || ((count == 2'd1) && pop);
  assign fire = hold_valid && room;

  assign in_ch.ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold.operation    <= in_ch.operation;
      hold.seq_num      <= in_ch.seq_num;
      hold.frag_count   <= in_ch.frag_count;
      hold.payload_size <= in_ch.payload_size;
      hold.frame_len    <= in_ch.frame_len;
      hold.data_byte    <= in_ch.data_byte;
    end
  end

  // Arithmetic on the held item.
  assign product  = {16'd0, hold.payload_size} * {16'd0, hold.frag_count};
  assign cap_calc = (product == 32'd0) ? DEFAULT_CAP : product;
  assign need_len = {1'b0, hold.payload_size} + {1'b0, HDR_BYTES};
  assign recv_sum = SUM_W'(st.received) + SUM_W'(hold.payload_size);
  // A restart begins from zero received bytes.
  assign recv_new_wide = (hold.seq_num == 16'd0) ? SUM_W'(hold.payload_size) : recv_sum;
  assign recv_new      = recv_new_wide[CAP_W-1:0];
  assign is_last_frag  = (hold.seq_num == (hold.frag_count - 16'd1));
  // A stored idle count is always below the timeout_ticks value it was checked
  // against, so the increment cannot wrap a 16-bit count.
  assign idle_inc = st.idle_ticks + 16'd1;

  always_comb begin
    st_next = st;
    res0    = '0;
    res1    = '0;
    nres    = 2'd0;
    case (hold.operation)
      OP_HEADER: begin
        if (hold.frame_len < HDR_BYTES) begin
          res0.kind = KIND_TOO_SHORT;
          nres      = 2'd1;
        end else if (need_len > {1'b0, hold.frame_len}) begin
          res0.kind = KIND_LENGTH_BAD;
          nres      = 2'd1;
        end else if ((hold.seq_num == 16'd0) && (cap_calc > MAX_CAP)) begin
          res0.kind = KIND_TOO_LARGE;
          nres      = 2'd1;
          st_next   = '0;
        end else if ((hold.seq_num != 16'd0) && (hold.seq_num != st.next_seq)) begin
          res0.kind = KIND_MISSING;
          nres      = 2'd1;
          st_next   = '0;
        end else if ((hold.seq_num != 16'd0) && (recv_sum > SUM_W'(st.capacity))) begin
          // A restart never overflows: its capacity is at least its payload.
          res0.kind = KIND_TOO_LARGE;
          nres      = 2'd1;
          st_next   = '0;
        end else begin
          if (hold.seq_num == 16'd0) begin
            st_next.active        = 1'b1;
            st_next.capacity      = cap_calc[CAP_W-1:0];
            st_next.write_pointer = '0;
            st_next.next_seq      = 16'd1;
          end else begin
            st_next.write_pointer = st.received;
            st_next.next_seq      = st.next_seq + 16'd1;
          end
          st_next.received        = recv_new;
          st_next.idle_ticks      = 16'd0;
          st_next.pending         = hold.payload_size;
          st_next.pending_is_last = is_last_frag;
          res0.kind           = KIND_FRAG_OK;
          res0.fragment_index = hold.seq_num;
          res0.fragment_total = hold.frag_count;
          res0.fragment_bytes = hold.payload_size;
          nres                = 2'd1;
          // An empty last fragment completes the message at once.
          if (is_last_frag && (hold.payload_size == 16'd0)) begin
            res1.kind           = KIND_COMPLETE;
            res1.message_length = to_msg(recv_new);
            nres                = 2'd2;
            st_next             = '0;
          end
        end
      end
      OP_BYTE: begin
        if (st.pending != 16'd0) begin
          res0.kind             = KIND_BYTE_WRITE;
          res0.write_offset     = to_off(st.write_pointer);
          res0.write_data       = hold.data_byte;
          nres                  = 2'd1;
          st_next.write_pointer = st.write_pointer + CAP_W'(1);
          st_next.pending       = st.pending - 16'd1;
          if ((st.pending == 16'd1) && st.pending_is_last) begin
            res1.kind           = KIND_COMPLETE;
            res1.message_length = to_msg(st.received);
            nres                = 2'd2;
            st_next             = '0;
          end
        end else begin
          res0.kind = KIND_BYTE_IGNORED;
          nres      = 2'd1;
        end
      end
      OP_TICK: begin
        if (st.active) begin
          if (idle_inc >= timeout_ticks) begin
            res0.kind = KIND_TIMEOUT;
            nres      = 2'd1;
            st_next   = '0;
          end else begin
            st_next.idle_ticks = idle_inc;
          end
        end
      end
      default: begin
        // The unused operation code is dropped without a result.
      end
    endcase
    if (nres == 2'd1) begin
      res0.last = 1'b1;
    end
    if (nres == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Two-entry result buffer: slot0 is shown, slot1 waits behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (fire) begin
      count <= nres;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign out_ch.valid          = (count != 2'd0);
  assign out_ch.kind           = slot0.kind;
  assign out_ch.fragment_index = slot0.fragment_index;
  assign out_ch.fragment_total = slot0.fragment_total;
  assign out_ch.fragment_bytes = slot0.fragment_bytes;
  assign out_ch.write_offset   = slot0.write_offset;
  assign out_ch.write_data     = slot0.write_data;
  assign out_ch.message_length = slot0.message_length;
  assign out_ch.last           = slot0.last;

endmodule

// File: hw/rtl/frc_assert.sv
// ----------------------------------------------------------------------------
// Fragment reassembly checker port assertions
// Checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "fragment_reassembly_checker_macros.svh"

module frc_assert (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [15:0] out_fragment_index,
  input logic [15:0] out_fragment_total,
  input logic [15:0] out_fragment_bytes,
  input logic [15:0] out_write_offset,
  input logic [7:0]  out_write_data,
  input logic [16:0] out_message_length,
  input logic        out_last
);
  import frc_pkg::*;

  // A stalled result keeps its payload.
  `FRC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_fragment_index) &&
    $stable(out_fragment_total) && $stable(out_fragment_bytes) &&
    $stable(out_write_offset) && $stable(out_write_data) &&
    $stable(out_message_length) && $stable(out_last),
    "stalled result changed")

  // Only an accepted fragment or a byte write can be followed by a second result.
  `FRC_ASSERT_SAME(a_first_kind, out_valid && !out_last,
    (out_kind == KIND_FRAG_OK) || (out_kind == KIND_BYTE_WRITE),
    "result without last has a wrong kind")

  // The second result of an item is the completion, right behind the first.
  `FRC_ASSERT_NEXT(a_second_complete, out_valid && out_ready && !out_last,
    out_valid && (out_kind == KIND_COMPLETE) && out_last,
    "second result of an item is not a completion")

  // Fragment progress fields are only carried by an accepted fragment.
  `FRC_ASSERT_SAME(a_progress_zero, out_valid && (out_kind != KIND_FRAG_OK),
    (out_fragment_index == 16'd0) && (out_fragment_total == 16'd0) &&
    (out_fragment_bytes == 16'd0),
    "progress fields set on a result that is not a fragment verdict")

endmodule

bind fragment_reassembly_checker frc_assert u_frc_assert (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_fragment_index (out_ch.fragment_index),
  .out_fragment_total (out_ch.fragment_total),
  .out_fragment_bytes (out_ch.fragment_bytes),
  .out_write_offset   (out_ch.write_offset),
  .out_write_data     (out_ch.write_data),
  .out_message_length (out_ch.message_length),
  .out_last           (out_ch.last)
);
